// ----- rtl/phfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phfe_pkg
// Types and constants shared by the packet header field extractor.
// ----------------------------------------------------------------------------
package phfe_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 65535;
    localparam int WINDOW_BYTES_DEF     = 128;
    localparam int LEN_W                = 16;
    localparam int L2_BYTES             = 18;
    localparam int L3_BYTES             = 40;
    localparam int L4_BYTES             = 4;
    localparam int NUM_CODES            = 23;

    localparam logic [15:0] ETH_VLAN = 16'h8100;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IPV6 = 16'h86dd;
    localparam logic [7:0]  PROTO_TCP  = 8'h06;
    localparam logic [7:0]  PROTO_UDP  = 8'h11;
    localparam logic [7:0]  PROTO_ICMP = 8'h01;

    localparam logic [4:0] C_NONE      = 5'd0;
    localparam logic [4:0] C_ETH_DST   = 5'd1;
    localparam logic [4:0] C_ETH_SRC   = 5'd2;
    localparam logic [4:0] C_ETH_TYPE  = 5'd3;
    localparam logic [4:0] C_VID       = 5'd4;
    localparam logic [4:0] C_PROTO     = 5'd5;
    localparam logic [4:0] C_V4_SRC    = 5'd6;
    localparam logic [4:0] C_V4_DST    = 5'd7;
    localparam logic [4:0] C_V6_SRC_HI = 5'd8;
    localparam logic [4:0] C_V6_SRC_LO = 5'd9;
    localparam logic [4:0] C_V6_DST_HI = 5'd10;
    localparam logic [4:0] C_V6_DST_LO = 5'd11;
    localparam logic [4:0] C_ARP_OP    = 5'd12;
    localparam logic [4:0] C_ARP_SHA   = 5'd13;
    localparam logic [4:0] C_ARP_THA   = 5'd14;
    localparam logic [4:0] C_ARP_SPA   = 5'd15;
    localparam logic [4:0] C_ARP_TPA   = 5'd16;
    localparam logic [4:0] C_TCP_SRC   = 5'd17;
    localparam logic [4:0] C_TCP_DST   = 5'd18;
    localparam logic [4:0] C_UDP_SRC   = 5'd19;
    localparam logic [4:0] C_UDP_DST   = 5'd20;
    localparam logic [4:0] C_ICMP_TYPE = 5'd21;
    localparam logic [4:0] C_ICMP_CODE = 5'd22;

    typedef struct packed {
        logic [LEN_W-1:0]               len;
        logic [L2_BYTES-1:0][7:0]       l2;
        logic [L3_BYTES-1:0][7:0]       l3;
        logic [L4_BYTES-1:0][7:0]       l4;
    } t_entry;

endpackage

// ----- rtl/phfe_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phfe_if
// Byte input channel and field output channel.
// ----------------------------------------------------------------------------
interface phfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] pkt_byte;
    logic       end_of_packet;

    modport source (output valid, output pkt_byte, output end_of_packet, input ready);
    modport sink   (input valid, input pkt_byte, input end_of_packet, output ready);
endinterface

interface phfe_field_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_code;
    logic [63:0] field_value;
    logic        last_field;

    modport source (output valid, output field_code, output field_value,
                    output last_field, input ready);
    modport sink   (input valid, input field_code, input field_value,
                    input last_field, output ready);
endinterface

// ----- rtl/phfe_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phfe_front
// Count packet bytes and capture L2, L3 and L4 header bytes as they stream.
// ----------------------------------------------------------------------------
module phfe_front #(
    parameter int MAX_PACKET_BYTES = phfe_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_pkt_byte,
    input  logic                i_end_of_packet,
    output logic                o_push,
    output phfe_pkg::t_entry    o_entry,
    input  logic                i_full
);

    localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [CW-1:0] CMAX = CW'(MAX_PACKET_BYTES);

    logic [CW-1:0] r_cnt, n_cnt;
    logic [phfe_pkg::L2_BYTES-1:0][7:0] r_l2, n_l2;
    logic [phfe_pkg::L3_BYTES-1:0][7:0] r_l3, n_l3;
    logic [phfe_pkg::L4_BYTES-1:0][7:0] r_l4, n_l4;

    logic          acc;
    logic          vlan;
    logic [15:0]   l3_type;
    logic [CW-1:0] l3_off, l4_off, d3, d4;
    logic [CW-1:0] len;

    assign o_ready = !i_full;
    assign acc     = i_valid && !i_full;
    assign vlan    = {r_l2[12], r_l2[13]} == phfe_pkg::ETH_VLAN;
    assign l3_type = vlan ? {r_l2[16], r_l2[17]} : {r_l2[12], r_l2[13]};
    assign l3_off  = vlan ? CW'(18) : CW'(14);
    assign l4_off  = l3_off + ((l3_type == phfe_pkg::ETH_IPV6) ? CW'(40)
                                : CW'({r_l3[0][3:0], 2'b00}));
    assign d3      = r_cnt - l3_off;
    assign d4      = r_cnt - l4_off;
    assign len     = (r_cnt < CMAX) ? r_cnt + CW'(1) : r_cnt;

    always_comb begin
        n_l2  = r_l2;
        n_l3  = r_l3;
        n_l4  = r_l4;
        n_cnt = r_cnt;
        if (acc) begin
            if (r_cnt < CW'(phfe_pkg::L2_BYTES)) begin
                n_l2[r_cnt[4:0]] = i_pkt_byte;
            end
            if (r_cnt >= CW'(14) && r_cnt >= l3_off && d3 < CW'(phfe_pkg::L3_BYTES)) begin
                n_l3[d3[5:0]] = i_pkt_byte;
            end
            if (r_cnt > CW'(14) && r_cnt > l3_off && r_cnt >= l4_off
                    && d4 < CW'(phfe_pkg::L4_BYTES)) begin
                n_l4[d4[1:0]] = i_pkt_byte;
            end
            n_cnt = i_end_of_packet ? '0 : len;
        end
    end

    assign o_push        = acc && i_end_of_packet;
    assign o_entry.len   = phfe_pkg::LEN_W'(len);
    assign o_entry.l2    = n_l2;
    assign o_entry.l3    = n_l3;
    assign o_entry.l4    = n_l4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_l2 <= n_l2;
        r_l3 <= n_l3;
        r_l4 <= n_l4;
    end

endmodule

// ----- rtl/phfe_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phfe_queue
// Two-entry queue of captured packet headers between front and back.
// ----------------------------------------------------------------------------
module phfe_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  phfe_pkg::t_entry i_entry,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output phfe_pkg::t_entry o_entry
);

    phfe_pkg::t_entry r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

// ----- rtl/phfe_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phfe_back
// Decode a captured header into a field mask and emit one field per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module phfe_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_pop,
    input  phfe_pkg::t_entry i_entry,
    phfe_field_if.source     o_fld
);

    localparam int NC = phfe_pkg::NUM_CODES;

    phfe_pkg::t_entry r_ent;
    logic [NC-1:0] r_mask, d_mask, rest;
    logic          r_busy, r_v4, d_v4;
    logic          r_ov, r_last;
    logic [4:0]    r_code, sel;
    logic [63:0]   r_val, val;
    logic          adv, last;

    logic          vlan, l2ok, is4, isa, is6, l4on;
    logic [15:0]   l3_type, len, rem, rem4;
    logic [5:0]    hl;
    logic [7:0]    proto;

    always_comb begin
        len     = i_entry.len;
        vlan    = {i_entry.l2[12], i_entry.l2[13]} == phfe_pkg::ETH_VLAN;
        l2ok    = vlan ? (len >= 16'd18) : (len >= 16'd14);
        l3_type = vlan ? {i_entry.l2[16], i_entry.l2[17]} : {i_entry.l2[12], i_entry.l2[13]};
        rem     = len - (vlan ? 16'd18 : 16'd14);
        hl      = {i_entry.l3[0][3:0], 2'b00};
        is4     = l2ok && l3_type == phfe_pkg::ETH_IPV4 && rem >= 16'd20;
        isa     = l2ok && l3_type == phfe_pkg::ETH_ARP && rem >= 16'd28
                  && {i_entry.l3[0], i_entry.l3[1]} == 16'h0001
                  && {i_entry.l3[2], i_entry.l3[3]} == phfe_pkg::ETH_IPV4
                  && i_entry.l3[4] == 8'd6 && i_entry.l3[5] == 8'd4;
        is6     = l2ok && l3_type == phfe_pkg::ETH_IPV6 && rem >= 16'd40;
        l4on    = (is4 && hl >= 6'd20 && rem > 16'(hl)) || (is6 && rem > 16'd40);
        rem4    = rem - (is6 ? 16'd40 : 16'(hl));
        proto   = is6 ? i_entry.l3[6] : i_entry.l3[9];
        d_v4    = is4;
        d_mask  = '0;
        d_mask[phfe_pkg::C_ETH_DST]   = l2ok;
        d_mask[phfe_pkg::C_ETH_SRC]   = l2ok;
        d_mask[phfe_pkg::C_ETH_TYPE]  = l2ok;
        d_mask[phfe_pkg::C_VID]       = l2ok && vlan;
        d_mask[phfe_pkg::C_PROTO]     = is4 || is6;
        d_mask[phfe_pkg::C_V4_SRC]    = is4;
        d_mask[phfe_pkg::C_V4_DST]    = is4;
        d_mask[phfe_pkg::C_V6_SRC_HI] = is6;
        d_mask[phfe_pkg::C_V6_SRC_LO] = is6;
        d_mask[phfe_pkg::C_V6_DST_HI] = is6;
        d_mask[phfe_pkg::C_V6_DST_LO] = is6;
        d_mask[phfe_pkg::C_ARP_OP]    = isa;
        d_mask[phfe_pkg::C_ARP_SHA]   = isa;
        d_mask[phfe_pkg::C_ARP_THA]   = isa;
        d_mask[phfe_pkg::C_ARP_SPA]   = isa;
        d_mask[phfe_pkg::C_ARP_TPA]   = isa;
        d_mask[phfe_pkg::C_TCP_SRC]   = l4on && proto == phfe_pkg::PROTO_TCP
                                        && rem4 >= 16'd20;
        d_mask[phfe_pkg::C_TCP_DST]   = d_mask[phfe_pkg::C_TCP_SRC];
        d_mask[phfe_pkg::C_UDP_SRC]   = l4on && proto == phfe_pkg::PROTO_UDP
                                        && rem4 >= 16'd8;
        d_mask[phfe_pkg::C_UDP_DST]   = d_mask[phfe_pkg::C_UDP_SRC];
        d_mask[phfe_pkg::C_ICMP_TYPE] = l4on && proto == phfe_pkg::PROTO_ICMP
                                        && rem4 >= 16'd4;
        d_mask[phfe_pkg::C_ICMP_CODE] = d_mask[phfe_pkg::C_ICMP_TYPE];
        d_mask[phfe_pkg::C_NONE]      = !l2ok;
    end

    always_comb begin
        sel = phfe_pkg::C_NONE;
        for (int k = NC - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                sel = 5'(k);
            end
        end
        rest = r_mask & ~(NC'(1) << sel);
        last = rest == '0;
    end

    always_comb begin
        case (sel)
            phfe_pkg::C_ETH_DST: begin
                val = 64'({r_ent.l2[0], r_ent.l2[1], r_ent.l2[2],
                           r_ent.l2[3], r_ent.l2[4], r_ent.l2[5]});
            end
            phfe_pkg::C_ETH_SRC: begin
                val = 64'({r_ent.l2[6], r_ent.l2[7], r_ent.l2[8],
                           r_ent.l2[9], r_ent.l2[10], r_ent.l2[11]});
            end
            phfe_pkg::C_ETH_TYPE: begin
                val = ({r_ent.l2[12], r_ent.l2[13]} == phfe_pkg::ETH_VLAN)
                      ? 64'({r_ent.l2[16], r_ent.l2[17]})
                      : 64'({r_ent.l2[12], r_ent.l2[13]});
            end
            phfe_pkg::C_VID:     val = 64'({r_ent.l2[14][3:0], r_ent.l2[15]});
            phfe_pkg::C_PROTO:   val = 64'(r_v4 ? r_ent.l3[9] : r_ent.l3[6]);
            phfe_pkg::C_V4_SRC: begin
                val = 64'({r_ent.l3[12], r_ent.l3[13], r_ent.l3[14], r_ent.l3[15]});
            end
            phfe_pkg::C_V4_DST: begin
                val = 64'({r_ent.l3[16], r_ent.l3[17], r_ent.l3[18], r_ent.l3[19]});
            end
            phfe_pkg::C_V6_SRC_HI: begin
                val = {r_ent.l3[8], r_ent.l3[9], r_ent.l3[10], r_ent.l3[11],
                       r_ent.l3[12], r_ent.l3[13], r_ent.l3[14], r_ent.l3[15]};
            end
            phfe_pkg::C_V6_SRC_LO: begin
                val = {r_ent.l3[16], r_ent.l3[17], r_ent.l3[18], r_ent.l3[19],
                       r_ent.l3[20], r_ent.l3[21], r_ent.l3[22], r_ent.l3[23]};
            end
            phfe_pkg::C_V6_DST_HI: begin
                val = {r_ent.l3[24], r_ent.l3[25], r_ent.l3[26], r_ent.l3[27],
                       r_ent.l3[28], r_ent.l3[29], r_ent.l3[30], r_ent.l3[31]};
            end
            phfe_pkg::C_V6_DST_LO: begin
                val = {r_ent.l3[32], r_ent.l3[33], r_ent.l3[34], r_ent.l3[35],
                       r_ent.l3[36], r_ent.l3[37], r_ent.l3[38], r_ent.l3[39]};
            end
            phfe_pkg::C_ARP_OP:  val = 64'({r_ent.l3[6], r_ent.l3[7]});
            phfe_pkg::C_ARP_SHA: begin
                val = 64'({r_ent.l3[8], r_ent.l3[9], r_ent.l3[10],
                           r_ent.l3[11], r_ent.l3[12], r_ent.l3[13]});
            end
            phfe_pkg::C_ARP_THA: begin
                val = 64'({r_ent.l3[18], r_ent.l3[19], r_ent.l3[20],
                           r_ent.l3[21], r_ent.l3[22], r_ent.l3[23]});
            end
            phfe_pkg::C_ARP_SPA: begin
                val = 64'({r_ent.l3[14], r_ent.l3[15], r_ent.l3[16], r_ent.l3[17]});
            end
            phfe_pkg::C_ARP_TPA: begin
                val = 64'({r_ent.l3[24], r_ent.l3[25], r_ent.l3[26], r_ent.l3[27]});
            end
            phfe_pkg::C_TCP_SRC, phfe_pkg::C_UDP_SRC: begin
                val = 64'({r_ent.l4[0], r_ent.l4[1]});
            end
            phfe_pkg::C_TCP_DST, phfe_pkg::C_UDP_DST: begin
                val = 64'({r_ent.l4[2], r_ent.l4[3]});
            end
            phfe_pkg::C_ICMP_TYPE: val = 64'(r_ent.l4[0]);
            phfe_pkg::C_ICMP_CODE: val = 64'(r_ent.l4[1]);
            default:     val = '0;
        endcase
    end

    assign adv   = r_busy && (!r_ov || o_fld.ready);
    assign o_pop = i_valid && (!r_busy || (adv && last));

    assign o_fld.valid       = r_ov;
    assign o_fld.field_code  = r_code;
    assign o_fld.field_value = r_val;
    assign o_fld.last_field  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (adv && last) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (o_fld.ready) begin
                r_ov <= 1'b0;
            end
        end
        if (o_pop) begin
            r_ent  <= i_entry;
            r_mask <= d_mask;
            r_v4   <= d_v4;
        end else if (adv) begin
            r_mask <= rest;
        end
        if (adv) begin
            r_code <= sel;
            r_val  <= val;
            r_last <= last;
        end
    end

endmodule

// ----- rtl/packet_header_field_extractor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_header_field_extractor_top
// Parse Ethernet/VLAN, IPv4/ARP/IPv6 and TCP/UDP/ICMP headers of a byte
// stream and emit the match fields of each packet.
//
// Channel  Dir  Payload                                   Handshake
// i_pkt    in   pkt_byte[7:0], end_of_packet              valid/ready
// o_fld    out  field_code[4:0], field_value[63:0],       valid/ready
//               last_field
//
// One byte per cycle is accepted while the queue is not full; the front captures header bytes in
// flight and hands each packet to a two-entry queue at its last byte.
// The back emits one field per cycle unless the output stalls, 1 to 11 fields per packet.
// Reset is synchronous, active low; no clearing pass is needed.
// Input stalls only while the queue is full; output stalls hold the
// output register.
// ----------------------------------------------------------------------------
module packet_header_field_extractor_top #(
    parameter int MAX_PACKET_BYTES = phfe_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    phfe_byte_if.sink    i_pkt,
    phfe_field_if.source o_fld
);

    phfe_pkg::t_entry push_entry, head_entry;
    logic push, full, head_valid, pop;

    phfe_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_pkt.valid),
        .o_ready         (i_pkt.ready),
        .i_pkt_byte      (i_pkt.pkt_byte),
        .i_end_of_packet (i_pkt.end_of_packet),
        .o_push          (push),
        .o_entry         (push_entry),
        .i_full          (full)
    );

    phfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .o_valid (head_valid),
        .i_pop   (pop),
        .o_entry (head_entry)
    );

    phfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .o_pop   (pop),
        .i_entry (head_entry),
        .o_fld   (o_fld)
    );

endmodule

// ----- tb/packet_header_field_extractor_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_header_field_extractor_top_tb
// Drives whole packets (Ethernet, VLAN, IPv4, ARP, IPv6, TCP, UDP, ICMP,
// truncated and malformed frames, one length-saturating frame) byte by byte,
// predicts the extracted fields of each packet and checks every output
// transaction in order, with random gaps on both channels and one long
// output stall.
// ----------------------------------------------------------------------------
module packet_header_field_extractor_top_tb;

    localparam int WIN       = phfe_pkg::WINDOW_BYTES_DEF;
    localparam int MAX_LEN   = phfe_pkg::MAX_PACKET_BYTES_DEF;
    localparam int MAX_FLDS  = 12;
    localparam int LIMIT     = 3000000;
    localparam int N_RANDOM  = 60;

    typedef enum int {
        L3_OTHER, L3_IPV4, L3_IPV4_BAD_IHL, L3_ARP, L3_ARP_BAD, L3_IPV6
    } l3_kind_e;

    typedef enum int { L4_OTHER, L4_TCP, L4_UDP, L4_ICMP } l4_kind_e;

    typedef struct {
        logic [4:0]  code;
        logic [63:0] value;
        logic        last;
    } field_t;

    typedef struct {
        bit       vlan;
        l3_kind_e l3;
        l4_kind_e l4;
        int       extra;
        bit       typed;
    } pkt_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    phfe_byte_if  pkt_if();
    phfe_field_if fld_if();

    packet_header_field_extractor_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_if),
        .o_fld   (fld_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic [7:0] hdr_window [WIN];
    int         rx_count;
    field_t     pkt_fields [$];
    field_t     fields_expected [$];
    bit         typed_pkts [$];
    logic [7:0] pkt_bytes [$];
    int         errors;
    int         cycles;
    int         rx_wait;
    int         idle_max;
    bit         hold_rx;

    pkt_row_t directed [] = '{
        '{0, L3_OTHER, L4_OTHER, -13, 1},
        '{0, L3_OTHER, L4_OTHER, -1, 1},
        '{1, L3_OTHER, L4_OTHER, -1, 1},
        '{0, L3_OTHER, L4_OTHER, 0, 0},
        '{0, L3_IPV4, L4_TCP, 0, 0},
        '{0, L3_IPV4, L4_UDP, 3, 0},
        '{0, L3_IPV4, L4_ICMP, 0, 0},
        '{0, L3_IPV4, L4_OTHER, 6, 0},
        '{0, L3_IPV4_BAD_IHL, L4_TCP, 0, 0},
        '{0, L3_IPV4, L4_TCP, -1, 0},
        '{0, L3_IPV4, L4_TCP, -21, 0},
        '{0, L3_ARP, L4_OTHER, 0, 0},
        '{0, L3_ARP_BAD, L4_OTHER, 0, 0},
        '{0, L3_IPV6, L4_TCP, 0, 0},
        '{0, L3_IPV6, L4_UDP, 0, 0},
        '{0, L3_IPV6, L4_TCP, -20, 0},
        '{1, L3_IPV4, L4_UDP, 0, 0},
        '{1, L3_ARP, L4_OTHER, 0, 0},
        '{1, L3_IPV6, L4_ICMP, 2, 0},
        '{1, L3_IPV4, L4_TCP, 150, 0},
        '{0, L3_IPV4, L4_TCP, 65600, 0}
    };

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic logic [63:0] win_rd(int off, int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
            v = {v[55:0], (off + i < WIN) ? hdr_window[off + i] : 8'h00};
        return v;
    endfunction

    function automatic void add_field(logic [4:0] code, logic [63:0] value);
        if (pkt_fields.size() < MAX_FLDS)
            pkt_fields.push_back('{code, value, 1'b0});
    endfunction

    function automatic void extract_l4(logic [7:0] proto, int o, int rem);
        if (proto == phfe_pkg::PROTO_TCP) begin
            if (rem >= 20) begin
                add_field(phfe_pkg::C_TCP_SRC, win_rd(o, 2));
                add_field(phfe_pkg::C_TCP_DST, win_rd(o + 2, 2));
            end
        end else if (proto == phfe_pkg::PROTO_UDP) begin
            if (rem >= 8) begin
                add_field(phfe_pkg::C_UDP_SRC, win_rd(o, 2));
                add_field(phfe_pkg::C_UDP_DST, win_rd(o + 2, 2));
            end
        end else if (proto == phfe_pkg::PROTO_ICMP) begin
            if (rem >= 4) begin
                add_field(phfe_pkg::C_ICMP_TYPE, win_rd(o, 1));
                add_field(phfe_pkg::C_ICMP_CODE, win_rd(o + 1, 1));
            end
        end
    endfunction

    function automatic void extract_l3(logic [15:0] etype, int o, int rem);
        int hl;
        if (etype == phfe_pkg::ETH_IPV4) begin
            if (rem >= 20) begin
                add_field(phfe_pkg::C_PROTO, win_rd(o + 9, 1));
                add_field(phfe_pkg::C_V4_SRC, win_rd(o + 12, 4));
                add_field(phfe_pkg::C_V4_DST, win_rd(o + 16, 4));
                hl = int'(win_rd(o, 1) & 64'h0f) * 4;
                if (hl >= 20 && rem > hl)
                    extract_l4(8'(win_rd(o + 9, 1)), o + hl, rem - hl);
            end
        end else if (etype == phfe_pkg::ETH_ARP) begin
            if (rem >= 28 && win_rd(o, 2) == 64'd1 &&
                win_rd(o + 2, 2) == 64'(phfe_pkg::ETH_IPV4) &&
                win_rd(o + 4, 1) == 64'd6 && win_rd(o + 5, 1) == 64'd4) begin
                add_field(phfe_pkg::C_ARP_OP, win_rd(o + 6, 2));
                add_field(phfe_pkg::C_ARP_SHA, win_rd(o + 8, 6));
                add_field(phfe_pkg::C_ARP_THA, win_rd(o + 18, 6));
                add_field(phfe_pkg::C_ARP_SPA, win_rd(o + 14, 4));
                add_field(phfe_pkg::C_ARP_TPA, win_rd(o + 24, 4));
            end
        end else if (etype == phfe_pkg::ETH_IPV6) begin
            if (rem >= 40) begin
                add_field(phfe_pkg::C_PROTO, win_rd(o + 6, 1));
                add_field(phfe_pkg::C_V6_SRC_HI, win_rd(o + 8, 8));
                add_field(phfe_pkg::C_V6_SRC_LO, win_rd(o + 16, 8));
                add_field(phfe_pkg::C_V6_DST_HI, win_rd(o + 24, 8));
                add_field(phfe_pkg::C_V6_DST_LO, win_rd(o + 32, 8));
                if (rem > 40)
                    extract_l4(8'(win_rd(o + 6, 1)), o + 40, rem - 40);
            end
        end
    endfunction

    function automatic void extract_fields(int len);
        pkt_fields.delete();
        if (len >= 14) begin
            if (win_rd(12, 2) == 64'(phfe_pkg::ETH_VLAN)) begin
                if (len >= 18) begin
                    add_field(phfe_pkg::C_ETH_DST, win_rd(0, 6));
                    add_field(phfe_pkg::C_ETH_SRC, win_rd(6, 6));
                    add_field(phfe_pkg::C_ETH_TYPE, win_rd(16, 2));
                    add_field(phfe_pkg::C_VID, win_rd(14, 2) & 64'h0fff);
                    extract_l3(16'(win_rd(16, 2)), 18, len - 18);
                end
            end else begin
                add_field(phfe_pkg::C_ETH_DST, win_rd(0, 6));
                add_field(phfe_pkg::C_ETH_SRC, win_rd(6, 6));
                add_field(phfe_pkg::C_ETH_TYPE, win_rd(12, 2));
                extract_l3(16'(win_rd(12, 2)), 14, len - 14);
            end
        end
        if (pkt_fields.size() == 0)
            pkt_fields.push_back('{phfe_pkg::C_NONE, 64'd0, 1'b0});
        pkt_fields[pkt_fields.size() - 1].last = 1'b1;
        foreach (pkt_fields[i])
            fields_expected.push_back(pkt_fields[i]);
    endfunction

    function automatic void push_rand(int n);
        repeat (n) pkt_bytes.push_back(8'($urandom));
    endfunction

    function automatic void push16(logic [15:0] v);
        pkt_bytes.push_back(v[15:8]);
        pkt_bytes.push_back(v[7:0]);
    endfunction

    function automatic void build_packet(pkt_row_t r);
        logic [15:0] etype;
        logic [7:0]  proto;
        int          ihl;
        int          len;
        pkt_bytes.delete();
        push_rand(12);
        if (r.vlan) begin
            push16(phfe_pkg::ETH_VLAN);
            push_rand(2);
        end
        case (r.l4)
            L4_TCP:  proto = phfe_pkg::PROTO_TCP;
            L4_UDP:  proto = phfe_pkg::PROTO_UDP;
            L4_ICMP: proto = phfe_pkg::PROTO_ICMP;
            default: begin
                proto = 8'($urandom);
                if (proto == phfe_pkg::PROTO_TCP || proto == phfe_pkg::PROTO_UDP ||
                    proto == phfe_pkg::PROTO_ICMP)
                    proto = 8'hff;
            end
        endcase
        case (r.l3)
            L3_IPV4, L3_IPV4_BAD_IHL: begin
                push16(phfe_pkg::ETH_IPV4);
                ihl = (r.l3 == L3_IPV4) ? $urandom_range(5, 15) : $urandom_range(0, 4);
                pkt_bytes.push_back({4'h4, 4'(ihl)});
                push_rand(8);
                pkt_bytes.push_back(proto);
                push_rand(10);
                if (ihl > 5) push_rand((ihl - 5) * 4);
            end
            L3_ARP, L3_ARP_BAD: begin
                push16(phfe_pkg::ETH_ARP);
                push16(16'h0001);
                push16(phfe_pkg::ETH_IPV4);
                pkt_bytes.push_back(8'd6);
                pkt_bytes.push_back(8'd4);
                push_rand(22);
                if (r.l3 == L3_ARP_BAD)
                    pkt_bytes[pkt_bytes.size() - 28 + $urandom_range(0, 5)] ^=
                        8'(1 << $urandom_range(0, 7));
            end
            L3_IPV6: begin
                push16(phfe_pkg::ETH_IPV6);
                push_rand(6);
                pkt_bytes.push_back(proto);
                push_rand(33);
            end
            default: begin
                etype = 16'($urandom);
                if (etype == phfe_pkg::ETH_VLAN || etype == phfe_pkg::ETH_IPV4 ||
                    etype == phfe_pkg::ETH_ARP || etype == phfe_pkg::ETH_IPV6)
                    etype = 16'hffff;
                push16(etype);
            end
        endcase
        if (r.l3 == L3_IPV4 || r.l3 == L3_IPV4_BAD_IHL || r.l3 == L3_IPV6) begin
            case (r.l4)
                L4_TCP:  push_rand(20);
                L4_UDP:  push_rand(8);
                L4_ICMP: push_rand(4);
                default: ;
            endcase
        end
        len = pkt_bytes.size() + r.extra;
        if (len < 1) len = 1;
        while (pkt_bytes.size() > len) void'(pkt_bytes.pop_back());
        if (pkt_bytes.size() < len) push_rand(len - pkt_bytes.size());
    endfunction

    task automatic send_packet(pkt_row_t r);
        int gap;
        build_packet(r);
        typed_pkts.push_back(r.typed);
        foreach (pkt_bytes[i]) begin
            gap = $urandom_range(0, idle_max);
            repeat (gap) begin
                @(negedge i_clk);
                pkt_if.valid <= 1'b0;
            end
            @(negedge i_clk);
            pkt_if.valid         <= 1'b1;
            pkt_if.pkt_byte      <= pkt_bytes[i];
            pkt_if.end_of_packet <= (i == pkt_bytes.size() - 1);
            do @(posedge i_clk); while (!pkt_if.ready);
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_rx) begin
            fld_if.ready <= 1'b0;
        end else if (rx_wait > 0) begin
            fld_if.ready <= 1'b0;
            rx_wait--;
        end else begin
            fld_if.ready <= 1'b1;
        end
    end

    initial begin
        hold_rx = 1'b0;
        wait (i_rst_n);
        repeat (1500) @(posedge i_clk);
        hold_rx = 1'b1;
        repeat (1200) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    always @(posedge i_clk) begin
        field_t want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else if (i_rst_n) begin
            if (pkt_if.valid && pkt_if.ready) begin
                if (rx_count < WIN) hdr_window[rx_count] = pkt_if.pkt_byte;
                if (rx_count < MAX_LEN) rx_count++;
                if (pkt_if.end_of_packet) begin
                    if (typed_pkts.pop_front())
                        fields_expected.push_back('{phfe_pkg::C_NONE, 64'd0, 1'b1});
                    else
                        extract_fields(rx_count);
                    rx_count = 0;
                end
            end
            if (fld_if.valid && fld_if.ready) begin
                rx_wait = $urandom_range(0, idle_max);
                if (fields_expected.size() == 0) begin
                    report("unexpected field", 64'(fld_if.field_code), 64'd0);
                end else begin
                    want = fields_expected.pop_front();
                    if (fld_if.field_code !== want.code)
                        report("field_code", 64'(fld_if.field_code), 64'(want.code));
                    if (fld_if.field_value !== want.value)
                        report("field_value", fld_if.field_value, want.value);
                    if (fld_if.last_field !== want.last)
                        report("last_field", 64'(fld_if.last_field), 64'(want.last));
                end
            end
        end
    end

    initial begin
        pkt_row_t r;
        errors   = 0;
        cycles   = 0;
        rx_count = 0;
        rx_wait  = 0;
        idle_max = 5;
        pkt_if.valid         = 1'b0;
        pkt_if.pkt_byte      = 8'h00;
        pkt_if.end_of_packet = 1'b0;
        fld_if.ready         = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i]) begin
            idle_max = (directed[i].extra > 1000 || i % 4 == 3) ? 0 : 5;
            send_packet(directed[i]);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            idle_max  = (n % 5 == 4) ? 0 : 5;
            r.vlan    = ($urandom_range(0, 3) == 0);
            r.l3      = l3_kind_e'($urandom_range(0, 5));
            r.l4      = l4_kind_e'($urandom_range(0, 3));
            r.typed   = 1'b0;
            case ($urandom_range(0, 9))
                0:       r.extra = -int'($urandom_range(1, 60));
                1:       r.extra = int'($urandom_range(60, 140));
                default: r.extra = int'($urandom_range(0, 12));
            endcase
            send_packet(r);
        end
        @(negedge i_clk);
        pkt_if.valid         <= 1'b0;
        pkt_if.end_of_packet <= 1'b0;
        while (fields_expected.size() != 0 || typed_pkts.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && fields_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
